/* sv/rotary_encoder_position_tracker_macros.svh */
// ----------------------------------------------------------------------------
// Rotary encoder position tracker assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_POSITION_TRACKER_MACROS_SVH
`define ROTARY_ENCODER_POSITION_TRACKER_MACROS_SVH

// same-cycle implication
`define REPT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define REPT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rept_pkg.sv */
// ----------------------------------------------------------------------------
// Rotary encoder position tracker package
// Decoder tables, register indexes, event codes and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rept_pkg;

  localparam logic HALF_STEP = 1'b0;

  localparam logic [5:0] DIR_CW   = 6'h10;
  localparam logic [5:0] DIR_CCW  = 6'h20;
  localparam logic [5:0] DIR_MASK = 6'h30;

  localparam logic [9:0] SPEED_DIVIDEND = 10'd1000;
  localparam logic [3:0] DIV_LAST       = 4'd9;

  localparam logic signed [15:0] LOWER_RST  = -16'sd32767;
  localparam logic signed [15:0] UPPER_RST  = 16'sd32766;
  localparam logic [9:0]         WINDOW_RST = 10'd100;
  localparam logic [9:0]         RATE_RST   = 10'd10;

  typedef enum logic [2:0] {
    CFG_LOWER     = 3'd0,
    CFG_UPPER     = 3'd1,
    CFG_NSTEP     = 3'd2,
    CFG_FSTEP     = 3'd3,
    CFG_WRAP      = 3'd4,
    CFG_THRESHOLD = 3'd5,
    CFG_WINDOW    = 3'd6,
    CFG_SWAP      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CW   = 2'd1,
    EV_CCW  = 2'd2
  } step_ev_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  localparam logic [5:0] FULL_TAB [7][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00}
  };

  localparam logic [5:0] HALF_TAB [6][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h03, 6'h20}
  };

  // next decoder state; rows beyond the table fall back to the start row
  function automatic logic [5:0] rept_dec_next(input logic [3:0] row,
                                               input logic [1:0] code);
    logic [2:0] r;
    logic [5:0] res;
    if (HALF_STEP) begin
      r   = (row >= 4'd6) ? 3'd0 : row[2:0];
      res = HALF_TAB[r][code];
    end else begin
      r   = (row >= 4'd7) ? 3'd0 : row[2:0];
      res = FULL_TAB[r][code];
    end
    return res;
  endfunction

endpackage

/* sv/rotary_encoder_position_tracker.sv */
// ----------------------------------------------------------------------------
// Rotary encoder position tracker
// Quadrature state-table decoder with speed-dependent step, bounded position
// and position load.
// ----------------------------------------------------------------------------
//  channel  | ports                       | request
//  ---------+-----------------------------+---------------------------------
//  in       | in_tvalid/tready/tdata/tuser | sample or load request
//  out      | out_tvalid/tready/tdata      | one result per request
//  cfg      | cfg_wr_en/addr/wdata         | register write, no read-back
//
//  One request per cycle while in_tready is high; an accepted request waits
//  in the input register and moves to the output register when that is free.
//  A write to window_ms starts a reciprocal divider (1000 / window);
//  in_tready stays low while it runs.
//  Reset is synchronous, active low; non-payload registers take reset values.
//  A stalled output holds its data; the input register takes one more
//  request, then in_tready drops until the output moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_position_tracker
  import rept_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // chan_a, chan_b, now_ms[15:0], load_value[15:0], pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // position[15:0], step_event[1:0], fast_active,
                                  // load_ok, pad
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic signed [15:0] lower_r, upper_r;
  logic [7:0]         nstep_r, fstep_r;
  logic               wrap_r, swap_r;
  logic [15:0]        thresh_r;
  logic [9:0]         win_r;

  logic               div_busy_r;
  logic [3:0]         div_cnt_r;
  logic [9:0]         div_rem_r, div_dvd_r, rate_r;
  logic [10:0]        div_trial;
  logic               div_ge;
  logic [10:0]        div_diff;
  logic [9:0]         win_wr;

  logic               s1_vld_r;
  logic               s1_cmd_r, s1_a_r, s1_b_r;
  logic [15:0]        s1_now_r;
  logic signed [15:0] s1_ld_r;

  logic [5:0]         dec_r;
  logic signed [15:0] pos_r;
  logic [15:0]        cnt_r, wstart_r;
  logic [25:0]        speed_r;

  logic               out_vld_r;
  logic [23:0]        out_data_r;

  logic               advance;
  logic [1:0]         code;
  logic [5:0]         dec_nxt, dir;
  logic               detent;
  logic [15:0]        cnt_inc, elapsed;
  logic               win_hit;
  logic [25:0]        prod, speed_sel;
  logic               fast;
  logic [7:0]         step;
  logic signed [17:0] pos_ext, step_ext, psum, lo_ext, up_ext;
  logic signed [15:0] pos_nxt;
  logic               ld_ok;
  step_ev_t           ev;

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !div_busy_r && (!s1_vld_r || advance);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // reciprocal divider, one quotient bit a cycle
  assign div_trial = {div_rem_r, div_dvd_r[9]};
  assign div_ge    = div_trial >= {1'b0, win_r};
  assign div_diff  = div_trial - {1'b0, win_r};
  assign win_wr    = (cfg_wdata[9:0] == 10'd0) ? 10'd1 : cfg_wdata[9:0];

  // decode and position update
  assign code     = swap_r ? {s1_a_r, s1_b_r} : {s1_b_r, s1_a_r};
  assign dec_nxt  = rept_dec_next(dec_r[3:0], code);
  assign dir      = dec_nxt & DIR_MASK;
  assign detent   = |dir;
  assign cnt_inc  = cnt_r + {15'd0, detent};
  assign elapsed  = s1_now_r - wstart_r;
  assign win_hit  = elapsed >= {6'd0, win_r};
  assign prod     = {10'd0, cnt_inc} * {16'd0, rate_r};
  assign speed_sel = win_hit ? prod : speed_r;
  assign fast     = speed_sel > {10'd0, thresh_r};
  assign step     = (fast && (fstep_r > nstep_r)) ? fstep_r : nstep_r;
  assign pos_ext  = {{2{pos_r[15]}}, pos_r};
  assign step_ext = {10'd0, step};
  assign lo_ext   = {{2{lower_r[15]}}, lower_r};
  assign up_ext   = {{2{upper_r[15]}}, upper_r};
  assign ld_ok    = (s1_ld_r >= lower_r) && (s1_ld_r <= upper_r);

  always_comb begin
    psum = (dir == DIR_CW) ? (pos_ext + step_ext) : (pos_ext - step_ext);
    if (psum > up_ext) begin
      pos_nxt = wrap_r ? lower_r : upper_r;
    end else if (psum < lo_ext) begin
      pos_nxt = wrap_r ? upper_r : lower_r;
    end else begin
      pos_nxt = psum[15:0];
    end
    if (dir == DIR_CW) begin
      ev = EV_CW;
    end else if (dir == DIR_CCW) begin
      ev = EV_CCW;
    end else begin
      ev = EV_NONE;
    end
  end

  // configuration and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r    <= LOWER_RST;
      upper_r    <= UPPER_RST;
      nstep_r    <= 8'd1;
      fstep_r    <= 8'd1;
      wrap_r     <= 1'b0;
      thresh_r   <= 16'd0;
      win_r      <= WINDOW_RST;
      swap_r     <= 1'b0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= 4'd0;
      div_rem_r  <= 10'd0;
      div_dvd_r  <= 10'd0;
      rate_r     <= RATE_RST;
    end else begin
      if (div_busy_r) begin
        div_rem_r <= div_ge ? div_diff[9:0] : div_trial[9:0];
        div_dvd_r <= {div_dvd_r[8:0], 1'b0};
        rate_r    <= {rate_r[8:0], div_ge};
        div_cnt_r <= div_cnt_r - 4'd1;
        if (div_cnt_r == 4'd0) begin
          div_busy_r <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOWER:     lower_r  <= cfg_wdata;
          CFG_UPPER:     upper_r  <= cfg_wdata;
          CFG_NSTEP:     nstep_r  <= cfg_wdata[7:0];
          CFG_FSTEP:     fstep_r  <= cfg_wdata[7:0];
          CFG_WRAP:      wrap_r   <= cfg_wdata[0];
          CFG_THRESHOLD: thresh_r <= cfg_wdata;
          CFG_WINDOW: begin
            win_r      <= win_wr;
            div_busy_r <= 1'b1;
            div_cnt_r  <= DIV_LAST;
            div_rem_r  <= 10'd0;
            div_dvd_r  <= SPEED_DIVIDEND;
            rate_r     <= 10'd0;
          end
          CFG_SWAP:      swap_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      dec_r     <= 6'd0;
      pos_r     <= 16'sd0;
      cnt_r     <= 16'd0;
      speed_r   <= 26'd0;
      wstart_r  <= 16'd0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (advance) begin
        if (cmd_t'(s1_cmd_r) == CMD_LOAD) begin
          if (ld_ok) begin
            pos_r <= s1_ld_r;
          end
        end else begin
          dec_r <= dec_nxt;
          if (win_hit) begin
            cnt_r    <= 16'd0;
            speed_r  <= prod;
            wstart_r <= s1_now_r;
          end else begin
            cnt_r <= cnt_inc;
          end
          if (ev != EV_NONE) begin
            pos_r <= pos_nxt;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_a_r   <= in_tdata[0];
      s1_b_r   <= in_tdata[1];
      s1_now_r <= in_tdata[17:2];
      s1_ld_r  <= in_tdata[33:18];
    end
    if (advance) begin
      if (cmd_t'(s1_cmd_r) == CMD_LOAD) begin
        out_data_r <= {4'd0, ld_ok, 1'b0, EV_NONE, (ld_ok ? s1_ld_r : pos_r)};
      end else begin
        out_data_r <= {4'd0, 1'b0, fast, ev, ((ev != EV_NONE) ? pos_nxt : pos_r)};
      end
    end
  end

endmodule

/* sv/rept_checker.sv */
// ----------------------------------------------------------------------------
// Rotary encoder position tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotary_encoder_position_tracker_macros.svh"

module rept_checker
  import rept_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_addr
);

  `REPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `REPT_ASSERT_IMP(a_ev_code, clk, rst_n, out_tvalid, out_tdata[17:16] == EV_NONE || out_tdata[17:16] == EV_CW || out_tdata[17:16] == EV_CCW, "bad step event code")
  `REPT_ASSERT_IMP(a_load_excl, clk, rst_n, out_tvalid && out_tdata[19], out_tdata[17:16] == EV_NONE && !out_tdata[18], "load result carries a detent")
  `REPT_ASSERT_NXT(a_win_stall, clk, rst_n, cfg_wr_en && cfg_addr == CFG_WINDOW, !in_tready, "input open during divider run")

endmodule

bind rotary_encoder_position_tracker rept_checker u_rept_checker (.*);

/* dv/tb_rotary_encoder_position_tracker.sv */
// ----------------------------------------------------------------------------
// Rotary encoder position tracker testbench
// Drives sample and load requests through the stream input and checks every
// result against an in-bench tracker: decoder table, speed window, step
// selection and clamp or wrap at the bounds. Directed tests cover the
// register extremes, crossed bounds, odd windows and a long detent count
// with the window held open; random phases then run quadrature sequences
// under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotary_encoder_position_tracker
  import rept_pkg::*;
();

  localparam int  CLK_HALF     = 2;
  localparam int  RST_CYCLES   = 5;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  MAX_REPORTS  = 40;
  localparam time TIMEOUT_NS   = 10_000_000;

  localparam logic [5:0] DIR_BITS = 6'h30;
  localparam logic [5:0] TURN_CW  = 6'h10;
  localparam logic [5:0] TURN_CCW = 6'h20;

  localparam logic [5:0] FULL_ROWS [7][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00}
  };

  localparam logic [5:0] HALF_ROWS [6][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h03, 6'h20}
  };

  // pin codes {b, a} in clockwise order, starting at rest
  localparam logic [1:0] GRAY_CW [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  typedef struct {
    logic signed [15:0] pos;
    step_ev_t           ev;
    logic               fast;
    logic               ok;
  } track_res_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // chan_a, chan_b, now_ms[15:0], load_value[15:0], pad
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // position[15:0], step_event[1:0], fast_active, load_ok, pad
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  // tracker shadow: configuration
  logic signed [15:0] lo_bound, hi_bound;
  logic [7:0]         nstep, fstep;
  logic               wrap_en, swap_en;
  logic [15:0]        thresh;
  logic [9:0]         win_cfg;
  // tracker shadow: state
  logic [5:0]         dec_st;
  logic signed [15:0] pos_q;
  logic [15:0]        det_cnt;
  logic [25:0]        speed;
  logic [15:0]        win_start;

  track_res_t pending_results[$];
  int         fail_count = 0;

  // stimulus state
  logic [1:0]  rot_phase = 2'd0;
  bit          spin_cw = 1'b1;
  logic [15:0] clock_ms = '0;
  int          ms_per_turn = 1;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          rx_gap = 0;

  rotary_encoder_position_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_tracker();
    lo_bound  = -16'sd32767;
    hi_bound  = 16'sd32766;
    nstep     = 8'd1;
    fstep     = 8'd1;
    wrap_en   = 1'b0;
    thresh    = '0;
    win_cfg   = 10'd100;
    swap_en   = 1'b0;
    dec_st    = '0;
    pos_q     = '0;
    det_cnt   = '0;
    speed     = '0;
    win_start = '0;
  endfunction

  function automatic track_res_t track_position(cmd_t cmd, logic a, logic b,
                                                logic [15:0] now,
                                                logic signed [15:0] ld);
    track_res_t  r;
    logic [1:0]  code;
    logic [5:0]  dir;
    logic [15:0] elapsed;
    logic [3:0]  row;
    logic [2:0]  row_sel;
    int          win;
    int          step;
    int          p;
    r.ev   = EV_NONE;
    r.fast = 1'b0;
    r.ok   = 1'b0;
    if (cmd == CMD_LOAD) begin
      if (ld >= lo_bound && ld <= hi_bound) begin
        pos_q = ld;
        r.ok  = 1'b1;
      end
    end else begin
      code = swap_en ? {a, b} : {b, a};
      row  = dec_st[3:0];
      if (HALF_STEP) begin
        row_sel = (row >= 4'd6) ? 3'd0 : row[2:0];
        dec_st  = HALF_ROWS[row_sel][code];
      end else begin
        row_sel = (row >= 4'd7) ? 3'd0 : row[2:0];
        dec_st  = FULL_ROWS[row_sel][code];
      end
      dir = dec_st & DIR_BITS;
      if (dir != '0) det_cnt = det_cnt + 16'd1;
      win     = (win_cfg == '0) ? 1 : int'(win_cfg);
      elapsed = now - win_start;
      if (elapsed >= 16'(win)) begin
        speed     = 26'(det_cnt * (1000 / win));
        win_start = now;
        det_cnt   = '0;
      end
      step = int'(nstep);
      if (speed > {10'd0, thresh}) begin
        r.fast = 1'b1;
        if (fstep > nstep) step = int'(fstep);
      end
      if (dir == TURN_CW || dir == TURN_CCW) begin
        p = int'(pos_q);
        if (dir == TURN_CW) begin
          p    = p + step;
          r.ev = EV_CW;
        end else begin
          p    = p - step;
          r.ev = EV_CCW;
        end
        if (p > int'(hi_bound)) p = wrap_en ? int'(lo_bound) : int'(hi_bound);
        else if (p < int'(lo_bound)) p = wrap_en ? int'(hi_bound) : int'(lo_bound);
        pos_q = p[15:0];
      end
    end
    r.pos = pos_q;
    return r;
  endfunction

  // receiver: random stalls plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap     <= 0;
      hold_left  <= 0;
    end else if (hold_asked != hold_done) begin
      hold_done  <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_gap     <= rx_idle_en ? pick_gap() : 0;
    end
  end

  task automatic note_mismatch(string what, int want, int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    track_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: result with no request pending, expected none, actual %h",
                   $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (want.pos != $signed(out_tdata[15:0]))
          note_mismatch("position", want.pos, $signed(out_tdata[15:0]));
        if (want.ev != out_tdata[17:16])
          note_mismatch("step_event", want.ev, out_tdata[17:16]);
        if (want.fast != out_tdata[18])
          note_mismatch("fast_active", want.fast, out_tdata[18]);
        if (want.ok != out_tdata[19])
          note_mismatch("load_ok", want.ok, out_tdata[19]);
      end
    end
  end

  task automatic send_request(cmd_t cmd, logic a, logic b, logic [15:0] now,
                              logic signed [15:0] ld);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, ld, now, b, a};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(track_position(cmd, a, b, now, ld));
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(logic signed [15:0] v);
    send_request(CMD_LOAD, 1'($urandom), 1'($urandom), 16'($urandom), v);
  endtask

  function automatic logic [1:0] phase_of(logic [1:0] code);
    logic [1:0] ph;
    ph = 2'd0;
    for (int i = 0; i < 4; i++)
      if (GRAY_CW[i[1:0]] == code) ph = i[1:0];
    return ph;
  endfunction

  task automatic send_code(logic [1:0] code);
    rot_phase = phase_of(code);
    send_request(CMD_SAMPLE, code[0], code[1], clock_ms, 16'($urandom));
    clock_ms = clock_ms + 16'(ms_per_turn);
  endtask

  task automatic turn(bit cw);
    send_code(GRAY_CW[cw ? rot_phase + 2'd1 : rot_phase - 2'd1]);
  endtask

  task automatic spin(bit cw, int detents);
    repeat (4 * detents) turn(cw);
  endtask

  // drop valid, drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LOWER:     lo_bound = val;
      CFG_UPPER:     hi_bound = val;
      CFG_NSTEP:     nstep    = val[7:0];
      CFG_FSTEP:     fstep    = val[7:0];
      CFG_WRAP:      wrap_en  = val[0];
      CFG_THRESHOLD: thresh   = val;
      CFG_WINDOW:    win_cfg  = val[9:0];
      CFG_SWAP:      swap_en  = val[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_load_value();
    int r;
    int span;
    r    = $urandom_range(0, 99);
    span = int'(hi_bound) - int'(lo_bound);
    if (r < 45 && span >= 0) return 16'(int'(lo_bound) + int'($urandom_range(0, span)));
    if (r < 60) return 16'(int'(hi_bound) + int'($urandom_range(0, 4)) - 2);
    if (r < 75) return 16'(int'(lo_bound) + int'($urandom_range(0, 4)) - 2);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'd255;
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic random_traffic(int n);
    int roll;
    repeat (n) begin
      roll        = $urandom_range(0, 99);
      ms_per_turn = $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) clock_ms = 16'($urandom);
      if (roll < 7) send_load(pick_load_value());
      else if (roll < 11) send_code(2'($urandom));
      else if (roll < 15) send_code(GRAY_CW[rot_phase]);
      else begin
        if ($urandom_range(0, 99) < 6) spin_cw = !spin_cw;
        turn(spin_cw);
      end
    end
  endtask

  task automatic test_reset_defaults();
    ms_per_turn = 1;
    spin(1'b1, 1);
    spin(1'b0, 1);
    send_load(16'sh8000);
    send_load(16'sh7FFF);
    send_load(-16'sd32767);
    send_load(16'sd32766);
    send_load(16'sd12345);
    send_code(2'b00);
    send_code(2'b11);
    clock_ms = 16'hFFFF;
    send_code(2'b11);
    turn(1'b1);
  endtask

  task automatic test_bounds_and_steps();
    wait_idle();
    write_reg(CFG_LOWER, 16'h8000);
    write_reg(CFG_UPPER, 16'h7FFF);
    write_reg(CFG_NSTEP, 16'd255);
    write_reg(CFG_FSTEP, 16'd0);
    write_reg(CFG_WRAP, 16'd0);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    send_code(2'b11);
    send_load(16'sd32700);
    spin(1'b1, 2);
    wait_idle();
    write_reg(CFG_WRAP, 16'd1);
    send_load(16'sd32700);
    spin(1'b1, 1);
    spin(1'b0, 1);
    // crossed bounds: above upper wins
    wait_idle();
    write_reg(CFG_LOWER, 16'd100);
    write_reg(CFG_UPPER, 16'(-100));
    send_load(16'sd0);
    spin(1'b1, 1);
    wait_idle();
    write_reg(CFG_WRAP, 16'd0);
    spin(1'b0, 1);
    wait_idle();
    write_reg(CFG_LOWER, 16'h8000);
    write_reg(CFG_UPPER, 16'h7FFF);
    write_reg(CFG_NSTEP, 16'd0);
    write_reg(CFG_SWAP, 16'd1);
    spin(1'b1, 1);
    wait_idle();
    write_reg(CFG_SWAP, 16'd0);
  endtask

  task automatic test_speed_windows();
    wait_idle();
    write_reg(CFG_NSTEP, 16'd1);
    write_reg(CFG_FSTEP, 16'd255);
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WINDOW, 16'd0);
    ms_per_turn = 1;
    spin(1'b1, 2);
    wait_idle();
    write_reg(CFG_WINDOW, 16'd1);
    spin(1'b0, 1);
    wait_idle();
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    spin(1'b0, 1);
    wait_idle();
    write_reg(CFG_THRESHOLD, 16'd3);
    write_reg(CFG_WINDOW, 16'd1000);
    ms_per_turn = 50;
    spin(1'b1, 6);
    wait_idle();
    write_reg(CFG_WINDOW, 16'd1023);
    spin(1'b1, 3);
    wait_idle();
    write_reg(CFG_WINDOW, 16'd7);
    write_reg(CFG_THRESHOLD, 16'd100);
    ms_per_turn = 2;
    spin(1'b0, 3);
  endtask

  // hold the timestamp so the window stays open while detents pile up
  task automatic test_count_hold();
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_reg(CFG_WINDOW, 16'd1000);
    write_reg(CFG_THRESHOLD, 16'd2);
    ms_per_turn = 0;
    clock_ms    = clock_ms + 16'd2000;
    send_code(2'b11);
    spin(1'b1, 12);
    clock_ms = clock_ms + 16'd1000;
    send_code(GRAY_CW[rot_phase]);
    send_code(GRAY_CW[rot_phase]);
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_asked++;
    random_traffic(80);
  endtask

  task automatic random_setup(int ph);
    int r;
    wait_idle();
    r = $urandom_range(0, 9);
    if (r == 0) begin
      write_reg(CFG_LOWER, 16'h8000);
      write_reg(CFG_UPPER, 16'h7FFF);
    end else if (r == 1) begin
      write_reg(CFG_LOWER, 16'($urandom_range(0, 200)));
      write_reg(CFG_UPPER, 16'(-int'($urandom_range(0, 200))));
    end else begin
      write_reg(CFG_LOWER, 16'(-int'($urandom_range(0, 300))));
      write_reg(CFG_UPPER, 16'($urandom_range(0, 300)));
    end
    write_reg(CFG_NSTEP, pick_step());
    write_reg(CFG_FSTEP, pick_step());
    write_reg(CFG_WRAP, 16'($urandom_range(0, 1)));
    write_reg(CFG_SWAP, 16'($urandom_range(0, 1)));
    case ($urandom_range(0, 7))
      0:       write_reg(CFG_WINDOW, 16'd0);
      1:       write_reg(CFG_WINDOW, 16'd1);
      2:       write_reg(CFG_WINDOW, 16'd1000);
      3:       write_reg(CFG_WINDOW, 16'd1023);
      default: write_reg(CFG_WINDOW, 16'($urandom_range(2, 40)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(CFG_THRESHOLD, 16'd0);
      1:       write_reg(CFG_THRESHOLD, 16'hFFFF);
      default: write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 400)));
    endcase
    tx_idle_en = (ph % 3 != 0);
    rx_idle_en = (ph % 3 != 1);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      random_setup(ph);
      random_traffic(120);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    reset_tracker();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_bounds_and_steps();
    test_speed_windows();
    test_count_hold();
    test_backpressure();
    test_random_phases();

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rept_pkg.sv
sv/rotary_encoder_position_tracker.sv
sv/rept_checker.sv
dv/tb_rotary_encoder_position_tracker.sv
